// ----- src/scp_pkg.sv -----
// scp_pkg: shared types and constants for the segment portal crossing block.
// Depends on nothing; used by the interfaces and every module in src.
package scp_pkg;

   localparam int unsigned CrdW  = 32;        // Q24.8 coordinate
   localparam int unsigned DltW  = CrdW + 1;  // difference of two coordinates
   localparam int unsigned AxW   = 21;        // one Q1.19 axis component
   localparam int unsigned PrdW  = DltW + AxW; // one dot-product term
   localparam int unsigned DotW  = PrdW + 2;  // sum of three terms
   localparam int unsigned DivW  = DotW + 2;  // divider remainder and divisor
   localparam int unsigned FrcW  = 17;        // Q0.16 fraction, 0..65536
   localparam int unsigned FrcSteps = FrcW - 1;
   localparam int unsigned TmW   = DltW + FrcW + 1; // diff times fraction
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrW    = 64;

   typedef logic signed [CrdW-1:0] crd_type;
   typedef logic signed [DltW-1:0] dlt_type;
   typedef logic signed [PrdW-1:0] prd_type;
   typedef logic signed [DotW-1:0] dot_type;
   typedef logic [DivW-1:0]        div_type;
   typedef logic [FrcW-1:0]        frc_type;
   typedef logic signed [TmW-1:0]  tm_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ORIGIN_X    = 3'd0,
      CSR_ORIGIN_Y    = 3'd1,
      CSR_ORIGIN_Z    = 3'd2,
      CSR_WIDTH_AXIS  = 3'd3,
      CSR_HEIGHT_AXIS = 3'd4,
      CSR_NORMAL      = 3'd5,
      CSR_HALF_EXTENT = 3'd6,
      CSR_LENIENCY    = 3'd7
   } csr_idx_type;

   // segment data that rides along with the divider
   typedef struct packed {
      logic             cand;
      logic [3*CrdW-1:0] s;
      logic [3*DltW-1:0] diff;
   } seg_type;

endpackage

// ----- src/scp_if.sv -----
// scp_if: valid/ready channel interfaces for segment items and crossing results.
// Depends on scp_pkg for the field types.
interface scp_req_if;
   logic            valid;
   logic            ready;
   scp_pkg::crd_type start_x;
   scp_pkg::crd_type start_y;
   scp_pkg::crd_type start_z;
   scp_pkg::crd_type end_x;
   scp_pkg::crd_type end_y;
   scp_pkg::crd_type end_z;
   modport source(output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
   modport sink(input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface scp_rsp_if;
   logic             valid;
   logic             ready;
   logic             hit;
   scp_pkg::frc_type fraction;
   scp_pkg::crd_type cross_x;
   scp_pkg::crd_type cross_y;
   scp_pkg::crd_type cross_z;
   modport source(output valid, hit, fraction, cross_x, cross_y, cross_z,
                  input ready);
   modport sink(input valid, hit, fraction, cross_x, cross_y, cross_z,
                output ready);
endinterface

// ----- src/segment_portal_crossing.sv -----
// segment_portal_crossing: top level of the portal crossing pipeline.
// Depends on scp_pkg, scp_if, scp_dist, scp_div and scp_proj.
//
// Tests each segment item against a rectangular portal and returns one result
// item per segment, in order. The pipeline takes a new item every cycle; in it
// 3 stages form the plane distances, 17 divider stages give one bit each of
// the Q0.16 fraction, 4 stages form the crossing point and its projection, and
// the output register holds the result. The whole pipeline advances together;
// it halts only while a finished result sits in the output register and the
// sink is not ready, so nothing is dropped or repeated. A hit needs a
// front-to-back crossing (d0 > 0, d1 <= 0) whose point lies within the half
// extents plus leniency; on a miss the fraction and the point read zero. Write
// the portal registers through the csr_ port only while no item is in flight.
module segment_portal_crossing (
   input  logic clock,
   input  logic reset,
   scp_req_if.sink   req_ch,
   scp_rsp_if.source rsp_ch,
   input  logic                          csr_we,
   input  scp_pkg::csr_idx_type          csr_index,
   input  logic [scp_pkg::CsrW-1:0]      csr_wdata
);
   // portal registers
   logic [3*scp_pkg::CrdW-1:0] origin_ff;
   logic [3*scp_pkg::AxW-1:0]  waxis_ff, haxis_ff, normal_ff;
   logic [63:0]                half_ff;
   logic [15:0]                len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         waxis_ff  <= 63'(64'd1 << 19);
         haxis_ff  <= 63'(64'd1 << 40);
         normal_ff <= 63'(64'd1 << 61);
         half_ff   <= {32'd256, 32'd256};
         len_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            scp_pkg::CSR_ORIGIN_X: begin
               origin_ff[0*scp_pkg::CrdW +: scp_pkg::CrdW] <= csr_wdata[31:0];
            end
            scp_pkg::CSR_ORIGIN_Y: begin
               origin_ff[1*scp_pkg::CrdW +: scp_pkg::CrdW] <= csr_wdata[31:0];
            end
            scp_pkg::CSR_ORIGIN_Z: begin
               origin_ff[2*scp_pkg::CrdW +: scp_pkg::CrdW] <= csr_wdata[31:0];
            end
            scp_pkg::CSR_WIDTH_AXIS:  waxis_ff  <= csr_wdata[62:0];
            scp_pkg::CSR_HEIGHT_AXIS: haxis_ff  <= csr_wdata[62:0];
            scp_pkg::CSR_NORMAL:      normal_ff <= csr_wdata[62:0];
            scp_pkg::CSR_HALF_EXTENT: half_ff   <= csr_wdata;
            scp_pkg::CSR_LENIENCY:    len_ff    <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // advance every stage unless the output register is stalled
   logic adv;
   logic rsp_valid_ff;
   assign adv          = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   logic             dist_valid, div_valid, proj_valid, proj_hit;
   scp_pkg::dot_type d0, d1;
   scp_pkg::seg_type dist_seg, div_seg;
   scp_pkg::frc_type div_t, proj_t;
   logic [3*scp_pkg::CrdW-1:0] proj_p;

   scp_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .in_s      ({req_ch.start_z, req_ch.start_y, req_ch.start_x}),
      .in_e      ({req_ch.end_z, req_ch.end_y, req_ch.end_x}),
      .origin    (origin_ff),
      .normal    (normal_ff),
      .out_valid (dist_valid),
      .out_d0    (d0),
      .out_d1    (d1),
      .out_seg   (dist_seg)
   );

   scp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dist_valid),
      .in_d0     (d0),
      .in_d1     (d1),
      .in_seg    (dist_seg),
      .out_valid (div_valid),
      .out_t     (div_t),
      .out_seg   (div_seg)
   );

   scp_proj u_proj (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (div_valid),
      .in_t        (div_t),
      .in_seg      (div_seg),
      .origin      (origin_ff),
      .width_axis  (waxis_ff),
      .height_axis (haxis_ff),
      .half_extent (half_ff),
      .leniency    (len_ff),
      .out_valid   (proj_valid),
      .out_hit     (proj_hit),
      .out_t       (proj_t),
      .out_p       (proj_p)
   );

   // output register; drop the payload to zero on a miss
   logic             hit_ff;
   scp_pkg::frc_type frac_ff;
   scp_pkg::crd_type cx_ff, cy_ff, cz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= proj_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= proj_hit;
         frac_ff <= proj_hit ? proj_t : '0;
         cx_ff   <= proj_hit ? proj_p[0*scp_pkg::CrdW +: scp_pkg::CrdW] : '0;
         cy_ff   <= proj_hit ? proj_p[1*scp_pkg::CrdW +: scp_pkg::CrdW] : '0;
         cz_ff   <= proj_hit ? proj_p[2*scp_pkg::CrdW +: scp_pkg::CrdW] : '0;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.hit      = hit_ff;
   assign rsp_ch.fraction = frac_ff;
   assign rsp_ch.cross_x  = cx_ff;
   assign rsp_ch.cross_y  = cy_ff;
   assign rsp_ch.cross_z  = cz_ff;
endmodule

// ----- src/scp_dist.sv -----
// scp_dist: three stages forming the plane distances d0 and d1 of a segment.
// Depends on scp_pkg.
module scp_dist (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic [3*scp_pkg::CrdW-1:0] in_s,
   input  logic [3*scp_pkg::CrdW-1:0] in_e,
   input  logic [3*scp_pkg::CrdW-1:0] origin,
   input  logic [3*scp_pkg::AxW-1:0]  normal,
   output logic                 out_valid,
   output scp_pkg::dot_type     out_d0,
   output scp_pkg::dot_type     out_d1,
   output scp_pkg::seg_type     out_seg
);
   logic [2:0] vld_ff;
   scp_pkg::dlt_type ds_ff [3], de_ff [3];
   scp_pkg::seg_type seg_a_ff, seg_b_ff, seg_c_ff;
   scp_pkg::prd_type ps_ff [3], pe_ff [3];
   scp_pkg::dot_type d0_ff, d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            ds_ff[k] <= scp_pkg::DltW'($signed(in_s[k*scp_pkg::CrdW +: scp_pkg::CrdW]))
                      - scp_pkg::DltW'($signed(origin[k*scp_pkg::CrdW +: scp_pkg::CrdW]));
            de_ff[k] <= scp_pkg::DltW'($signed(in_e[k*scp_pkg::CrdW +: scp_pkg::CrdW]))
                      - scp_pkg::DltW'($signed(origin[k*scp_pkg::CrdW +: scp_pkg::CrdW]));
            seg_a_ff.diff[k*scp_pkg::DltW +: scp_pkg::DltW] <=
               scp_pkg::DltW'($signed(in_e[k*scp_pkg::CrdW +: scp_pkg::CrdW]))
             - scp_pkg::DltW'($signed(in_s[k*scp_pkg::CrdW +: scp_pkg::CrdW]));
            // multiply by the normal
            ps_ff[k] <= ds_ff[k] * $signed(normal[k*scp_pkg::AxW +: scp_pkg::AxW]);
            pe_ff[k] <= de_ff[k] * $signed(normal[k*scp_pkg::AxW +: scp_pkg::AxW]);
         end
         seg_a_ff.s    <= in_s;
         seg_a_ff.cand <= 1'b0;
         seg_b_ff <= seg_a_ff;
         seg_c_ff <= seg_b_ff;
         d0_ff <= scp_pkg::DotW'(ps_ff[0]) + scp_pkg::DotW'(ps_ff[1])
                + scp_pkg::DotW'(ps_ff[2]);
         d1_ff <= scp_pkg::DotW'(pe_ff[0]) + scp_pkg::DotW'(pe_ff[1])
                + scp_pkg::DotW'(pe_ff[2]);
      end
   end

   assign out_valid = vld_ff[2];
   assign out_d0    = d0_ff;
   assign out_d1    = d1_ff;
   assign out_seg   = seg_c_ff;
endmodule

// ----- src/scp_div.sv -----
// scp_div: pipelined restoring divider, t = floor(d0 * 65536 / (d0 - d1)).
// Depends on scp_pkg; one quotient bit per stage.
module scp_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  scp_pkg::dot_type in_d0,
   input  scp_pkg::dot_type in_d1,
   input  scp_pkg::seg_type in_seg,
   output logic             out_valid,
   output scp_pkg::frc_type out_t,
   output scp_pkg::seg_type out_seg
);
   localparam int unsigned N = scp_pkg::FrcSteps;

   logic             vld_ff [N+1];
   scp_pkg::div_type rem_ff [N];
   scp_pkg::div_type den_ff [N];
   scp_pkg::frc_type q_ff   [N+1];
   scp_pkg::seg_type seg_ff [N+1];

   scp_pkg::div_type rem0, den0, sh [N];
   logic             cand;
   scp_pkg::seg_type seg0;

   always_comb begin
      cand = !in_d0[scp_pkg::DotW-1] && (in_d0 != '0)
          && (in_d1[scp_pkg::DotW-1] || (in_d1 == '0));
      seg0      = in_seg;
      seg0.cand = cand;
      den0 = scp_pkg::div_type'(scp_pkg::DivW'(in_d0) - scp_pkg::DivW'(in_d1));
      rem0 = scp_pkg::div_type'(scp_pkg::DivW'(in_d0));
      for (int i = 0; i < N; i++) begin
         sh[i] = {rem_ff[i][scp_pkg::DivW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= N; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int i = 0; i < N; i++) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0] <= den0;
         rem_ff[0] <= (rem0 >= den0) ? rem0 - den0 : rem0;
         q_ff[0]   <= scp_pkg::FrcW'(rem0 >= den0);
         seg_ff[0] <= seg0;
         for (int i = 0; i < N - 1; i++) begin
            den_ff[i+1] <= den_ff[i];
            rem_ff[i+1] <= (sh[i] >= den_ff[i]) ? sh[i] - den_ff[i] : sh[i];
         end
         for (int i = 0; i < N; i++) begin
            seg_ff[i+1] <= seg_ff[i];
            q_ff[i+1]   <= {q_ff[i][scp_pkg::FrcW-2:0], sh[i] >= den_ff[i]};
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_t     = q_ff[N];
   assign out_seg   = seg_ff[N];
endmodule

// ----- src/scp_proj.sv -----
// scp_proj: crossing point, projection onto the portal axes and bound test.
// Depends on scp_pkg; four register stages, result left combinational.
module scp_proj (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  scp_pkg::frc_type in_t,
   input  scp_pkg::seg_type in_seg,
   input  logic [3*scp_pkg::CrdW-1:0] origin,
   input  logic [3*scp_pkg::AxW-1:0]  width_axis,
   input  logic [3*scp_pkg::AxW-1:0]  height_axis,
   input  logic [63:0]      half_extent,
   input  logic [15:0]      leniency,
   output logic             out_valid,
   output logic             out_hit,
   output scp_pkg::frc_type out_t,
   output logic [3*scp_pkg::CrdW-1:0] out_p
);
   localparam int unsigned LimW = scp_pkg::CrdW + 1 + 19;

   logic [3:0] vld_ff;
   logic       cand_ff [4];
   scp_pkg::frc_type t_ff [4];
   scp_pkg::tm_type  tm_ff [3];
   scp_pkg::crd_type s_ff [3];
   scp_pkg::crd_type p_ff [3], p2_ff [3], p3_ff [3];
   scp_pkg::dlt_type dp_ff [3];
   scp_pkg::prd_type pu_ff [3], pv_ff [3];
   scp_pkg::dot_type u_ff, v_ff;

   scp_pkg::tm_type  shr [3];
   logic [scp_pkg::DotW-1:0] au, av;
   logic [LimW-1:0] lim_w, lim_h;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         shr[k] = tm_ff[k] >>> 16;  // floor of the scaled step
      end
      au    = u_ff[scp_pkg::DotW-1] ? -u_ff : u_ff;
      av    = v_ff[scp_pkg::DotW-1] ? -v_ff : v_ff;
      lim_w = {(33'(half_extent[31:0])  + 33'(leniency)), 19'b0};
      lim_h = {(33'(half_extent[63:32]) + 33'(leniency)), 19'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cand_ff[0] <= in_seg.cand;
         t_ff[0]    <= in_t;
         for (int i = 0; i < 3; i++) begin
            cand_ff[i+1] <= cand_ff[i];
            t_ff[i+1]    <= t_ff[i];
         end
         for (int k = 0; k < 3; k++) begin
            tm_ff[k] <= $signed(in_seg.diff[k*scp_pkg::DltW +: scp_pkg::DltW])
                      * $signed({1'b0, in_t});
            s_ff[k]  <= $signed(in_seg.s[k*scp_pkg::CrdW +: scp_pkg::CrdW]);
            p_ff[k]  <= s_ff[k] + shr[k][scp_pkg::CrdW-1:0];
            // the point lies between the endpoints, so it fits a signed coordinate
            dp_ff[k] <= scp_pkg::DltW'(scp_pkg::crd_type'(s_ff[k]
                                                         + shr[k][scp_pkg::CrdW-1:0]))
                      - scp_pkg::DltW'($signed(origin[k*scp_pkg::CrdW +: scp_pkg::CrdW]));
            p2_ff[k] <= p_ff[k];
            p3_ff[k] <= p2_ff[k];
            pu_ff[k] <= dp_ff[k] * $signed(width_axis[k*scp_pkg::AxW +: scp_pkg::AxW]);
            pv_ff[k] <= dp_ff[k] * $signed(height_axis[k*scp_pkg::AxW +: scp_pkg::AxW]);
         end
         u_ff <= scp_pkg::DotW'(pu_ff[0]) + scp_pkg::DotW'(pu_ff[1])
               + scp_pkg::DotW'(pu_ff[2]);
         v_ff <= scp_pkg::DotW'(pv_ff[0]) + scp_pkg::DotW'(pv_ff[1])
               + scp_pkg::DotW'(pv_ff[2]);
      end
   end

   assign out_valid = vld_ff[3];
   assign out_hit   = cand_ff[3] && (au <= scp_pkg::DotW'(lim_w))
                   && (av <= scp_pkg::DotW'(lim_h));
   assign out_t     = t_ff[3];
   assign out_p     = {p3_ff[2], p3_ff[1], p3_ff[0]};
endmodule
